// ===== src/kptt_pkg.sv =====
// Package for the keyed pending tag table.
// Holds the table size, derived widths, operation codes and shared types.
// Has no dependencies; every other file of the block imports it.
package kptt_pkg;

	// Table size and the widths that follow from it.
	localparam int DEPTH = 16;
	localparam int IDX_W = $clog2(DEPTH);
	localparam int CNT_W = $clog2(DEPTH + 1);
	localparam int SUM_W = CNT_W + 1;

	// Field widths of one item.
	localparam int KEY_W = 32;
	localparam int CAT_W = 8;
	localparam int FLG_W = 8;

	// Operation codes carried by func.
	localparam logic [1:0] FN_STORE   = 2'd0;
	localparam logic [1:0] FN_CONSUME = 2'd1;
	localparam logic [1:0] FN_CLEAR   = 2'd2;

	// One table entry.
	typedef struct packed {
		logic [KEY_W-1:0] key;
		logic [CAT_W-1:0] category;
		logic [FLG_W-1:0] flags;
	} entry_t;

	// Access request from the sequencer to the entry memory.
	typedef struct packed {
		logic             rd_en;
		logic [IDX_W-1:0] rd_addr;
		logic             wr_en;
		logic [IDX_W-1:0] wr_addr;
		entry_t           wr_data;
	} mem_req_t;

endpackage

// ===== src/kptt_mem.sv =====
// Entry memory of the keyed pending tag table.
// One write port and one read port with registered read data; no reset of contents.
// Depends on kptt_pkg for the entry type and the request struct.
module kptt_mem
	import kptt_pkg::*;
(
	input  logic     clk,
	input  mem_req_t req,
	output entry_t   rd_data
);

	entry_t mem_q [DEPTH];
	entry_t rd_data_q;

	// Write port.
	always_ff @(posedge clk) begin
		if (req.wr_en) begin
			mem_q[req.wr_addr] <= req.wr_data;
		end
	end

	// Registered read port.
	always_ff @(posedge clk) begin
		if (req.rd_en) begin
			rd_data_q <= mem_q[req.rd_addr];
		end
	end

	assign rd_data = rd_data_q;

endmodule

// ===== src/kptt_seq.sv =====
// Sequencer of the keyed pending tag table: one key comparator and one index
// counter reused to scan and compact entries, plus the result register; appends write at the count.
// Depends on kptt_pkg; drives the entry memory through a mem_req_t request.
module kptt_seq
	import kptt_pkg::*;
(
	input  logic             clk,
	input  logic             arst_n,
	input  logic             in_valid,
	output logic             in_stall,
	input  logic [1:0]       func,
	input  logic [KEY_W-1:0] key,
	input  logic [CAT_W-1:0] category,
	input  logic [FLG_W-1:0] flags,
	output logic             out_valid,
	input  logic             out_stall,
	output logic             found,
	output logic [CAT_W-1:0] category_out,
	output logic [FLG_W-1:0] flags_out,
	output logic             evicted,
	output mem_req_t         mem_req,
	input  entry_t           rd_data
);

	localparam logic [2:0] S_IDLE  = 3'd0;
	localparam logic [2:0] S_SCAN  = 3'd1;
	localparam logic [2:0] S_SHIFT = 3'd2;
	localparam logic [2:0] S_ADD   = 3'd3;
	localparam logic [2:0] S_DONE  = 3'd4;

	logic [2:0]       state_q;
	logic [CNT_W-1:0] count_q;
	logic [IDX_W-1:0] idx_q;

	// Latched item.
	logic [1:0]       func_q;
	logic [KEY_W-1:0] key_q;
	logic [CAT_W-1:0] cat_q;
	logic [FLG_W-1:0] flg_q;

	// Result being built, and the output register.
	logic             res_found_q;
	logic [CAT_W-1:0] res_cat_q;
	logic [FLG_W-1:0] res_flg_q;
	logic             res_evict_q;
	logic             out_valid_q;
	logic             found_q;
	logic [CAT_W-1:0] cat_out_q;
	logic [FLG_W-1:0] flg_out_q;
	logic             evicted_q;

	logic             match;
	logic [SUM_W-1:0] idx_ext;
	logic [SUM_W-1:0] nxt1;
	logic [SUM_W-1:0] nxt2;
	logic [SUM_W-1:0] cnt_ext;
	logic             more1;
	logic             more2;
	logic             full;
	logic             accept;
	logic             out_free;

	// The shared comparator and the index arithmetic.
	assign match    = (rd_data.key == key_q);
	assign idx_ext  = SUM_W'(idx_q);
	assign nxt1     = idx_ext + SUM_W'(1);
	assign nxt2     = idx_ext + SUM_W'(2);
	assign cnt_ext  = SUM_W'(count_q);
	assign more1    = (nxt1 < cnt_ext);
	assign more2    = (nxt2 < cnt_ext);
	assign full     = (cnt_ext == SUM_W'(DEPTH));
	assign accept   = in_valid && (state_q == S_IDLE);
	assign out_free = !out_valid_q || !out_stall;

	assign in_stall = (state_q != S_IDLE);

	// Memory requests for each step of the sequence.
	always_comb begin
		mem_req         = '0;
		mem_req.wr_addr = idx_q;
		mem_req.wr_data = '{key: key_q, category: cat_q, flags: flg_q};
		case (state_q)
			S_IDLE: begin
				mem_req.rd_en   = accept;
				mem_req.rd_addr = '0;
			end
			S_SCAN: begin
				if (match) begin
					if (func_q == FN_STORE) begin
						mem_req.wr_en = 1'b1;
					end else if (more1) begin
						mem_req.rd_en   = 1'b1;
						mem_req.rd_addr = nxt1[IDX_W-1:0];
					end
				end else if (more1) begin
					mem_req.rd_en   = 1'b1;
					mem_req.rd_addr = nxt1[IDX_W-1:0];
				end else if (func_q == FN_STORE && full) begin
					mem_req.rd_en   = 1'b1;
					mem_req.rd_addr = IDX_W'(1);
				end
			end
			S_SHIFT: begin
				mem_req.wr_en   = 1'b1;
				mem_req.wr_data = rd_data;
				if (more2) begin
					mem_req.rd_en   = 1'b1;
					mem_req.rd_addr = nxt2[IDX_W-1:0];
				end
			end
			S_ADD: begin
				mem_req.wr_en   = 1'b1;
				mem_req.wr_addr = count_q[IDX_W-1:0];
			end
			default: begin
			end
		endcase
	end

	// Item capture, without reset.
	always_ff @(posedge clk) begin
		if (accept) begin
			func_q <= func;
			key_q  <= key;
			cat_q  <= category;
			flg_q  <= flags;
		end
	end

	// Sequencer, entry count and result building.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q     <= S_IDLE;
			count_q     <= '0;
			idx_q       <= '0;
			res_found_q <= 1'b0;
			res_cat_q   <= '0;
			res_flg_q   <= '0;
			res_evict_q <= 1'b0;
		end else begin
			case (state_q)
				S_IDLE: begin
					if (accept) begin
						idx_q       <= '0;
						res_found_q <= 1'b0;
						res_cat_q   <= '0;
						res_flg_q   <= '0;
						res_evict_q <= 1'b0;
						if (func == FN_CLEAR) begin
							count_q <= '0;
							state_q <= S_DONE;
						end else if (func == FN_STORE || func == FN_CONSUME) begin
							if (count_q != '0) begin
								state_q <= S_SCAN;
							end else if (func == FN_STORE) begin
								state_q <= S_ADD;
							end else begin
								state_q <= S_DONE;
							end
						end else begin
							state_q <= S_DONE;
						end
					end
				end
				S_SCAN: begin
					if (match) begin
						res_found_q <= 1'b1;
						if (func_q == FN_STORE) begin
							state_q <= S_DONE;
						end else begin
							res_cat_q <= rd_data.category;
							res_flg_q <= rd_data.flags;
							if (more1) begin
								state_q <= S_SHIFT;
							end else begin
								count_q <= count_q - CNT_W'(1);
								state_q <= S_DONE;
							end
						end
					end else if (more1) begin
						idx_q <= nxt1[IDX_W-1:0];
					end else if (func_q == FN_STORE) begin
						if (full) begin
							res_evict_q <= 1'b1;
							idx_q       <= '0;
							state_q     <= S_SHIFT;
						end else begin
							state_q <= S_ADD;
						end
					end else begin
						state_q <= S_DONE;
					end
				end
				S_SHIFT: begin
					if (more2) begin
						idx_q <= nxt1[IDX_W-1:0];
					end else begin
						count_q <= count_q - CNT_W'(1);
						state_q <= (func_q == FN_STORE) ? S_ADD : S_DONE;
					end
				end
				S_ADD: begin
					count_q <= count_q + CNT_W'(1);
					state_q <= S_DONE;
				end
				S_DONE: begin
					if (out_free) begin
						state_q <= S_IDLE;
					end
				end
				default: begin
					state_q <= S_IDLE;
				end
			endcase
		end
	end

	// Output valid: set when a result moves in, cleared after its transfer.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			out_valid_q <= 1'b0;
		end else if (state_q == S_DONE && out_free) begin
			out_valid_q <= 1'b1;
		end else if (!out_stall) begin
			out_valid_q <= 1'b0;
		end
	end

	// Output payload, held while the result waits.
	always_ff @(posedge clk) begin
		if (state_q == S_DONE && out_free) begin
			found_q   <= res_found_q;
			cat_out_q <= res_cat_q;
			flg_out_q <= res_flg_q;
			evicted_q <= res_evict_q;
		end
	end

	assign out_valid    = out_valid_q;
	assign found        = found_q;
	assign category_out = cat_out_q;
	assign flags_out    = flg_out_q;
	assign evicted      = evicted_q;

endmodule

// ===== src/keyed_pending_tag_table.sv =====
// Keyed pending tag table: ordered key table with update, append, evict, consume and clear.
// A store or consume scans the entries in order, moves later entries down when a gap is
// closed, and appends a new key at the end; a new key on a full table evicts the oldest.
// No new item is taken until the current result has entered the output register; the
// one read port and the one key comparator serve each item's steps in turn.
// Reset (arst_n low) empties the table and drops any pending result; contents are not cleared.
module keyed_pending_tag_table
	import kptt_pkg::*;
(
	input  logic             clk,
	input  logic             arst_n,
	input  logic             in_valid,
	output logic             in_stall,
	input  logic [1:0]       func,
	input  logic [KEY_W-1:0] key,
	input  logic [CAT_W-1:0] category,
	input  logic [FLG_W-1:0] flags,
	output logic             out_valid,
	input  logic             out_stall,
	output logic             found,
	output logic [CAT_W-1:0] category_out,
	output logic [FLG_W-1:0] flags_out,
	output logic             evicted
);

	mem_req_t mem_req;
	entry_t   rd_data;

	// Sequencer with the shared comparator.
	kptt_seq u_seq (
		.clk          (clk),
		.arst_n       (arst_n),
		.in_valid     (in_valid),
		.in_stall     (in_stall),
		.func         (func),
		.key          (key),
		.category     (category),
		.flags        (flags),
		.out_valid    (out_valid),
		.out_stall    (out_stall),
		.found        (found),
		.category_out (category_out),
		.flags_out    (flags_out),
		.evicted      (evicted),
		.mem_req      (mem_req),
		.rd_data      (rd_data)
	);

	// Entry storage.
	kptt_mem u_mem (
		.clk     (clk),
		.req     (mem_req),
		.rd_data (rd_data)
	);

endmodule

// ===== src/kptt_checker.sv =====
// Port-level checker for the keyed pending tag table, with its bind statement.
// Depends on kptt_pkg for field widths; sees the top-level ports only.
module kptt_checker
	import kptt_pkg::*;
(
	input logic             clk,
	input logic             arst_n,
	input logic             in_valid,
	input logic             in_stall,
	input logic             out_valid,
	input logic             out_stall,
	input logic             found,
	input logic [CAT_W-1:0] category_out,
	input logic [FLG_W-1:0] flags_out,
	input logic             evicted
);

	// An accepted item keeps the block busy for at least the next cycle.
	a_busy_after_accept: assert property (@(posedge clk) disable iff (!arst_n)
		in_valid && !in_stall |=> in_stall)
		else $error("input taken twice in consecutive cycles");

	// A store cannot both update in place and evict.
	a_found_evict_excl: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid |-> !(found && evicted))
		else $error("result reports both found and evicted");

	// A result without a hit carries no category or flags.
	a_miss_zero: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid && !found |-> category_out == '0 && flags_out == '0)
		else $error("nonzero payload on a result without a hit");

	// A stalled result stays put.
	a_out_hold: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid && out_stall |=> out_valid && $stable(found) && $stable(evicted))
		else $error("stalled result changed");

endmodule

bind keyed_pending_tag_table kptt_checker u_kptt_checker (
	.clk          (clk),
	.arst_n       (arst_n),
	.in_valid     (in_valid),
	.in_stall     (in_stall),
	.out_valid    (out_valid),
	.out_stall    (out_stall),
	.found        (found),
	.category_out (category_out),
	.flags_out    (flags_out),
	.evicted      (evicted)
);
